// ----- design/bsc_pkg.sv -----
// Package for the barometric sensor compensation block.
// Holds register indexes, operation codes and constants; no dependencies.
`default_nettype none
package bsc_pkg;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAIR_A = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAIR_B = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAIR_C = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAIR_D = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PAIR_E = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OSS    = 3'd5;

   localparam logic OP_TEMPERATURE = 1'b0;
   localparam logic OP_PRESSURE    = 1'b1;

   localparam logic [31:0] B6_OFFSET   = 32'd4000;
   localparam logic [31:0] C_3038      = 32'd3038;
   localparam logic [31:0] C_M7357     = 32'hFFFF_E343;
   localparam logic [31:0] C_3791      = 32'd3791;
   localparam logic [31:0] C_50000     = 32'd50000;
   localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
   localparam logic [31:0] C_32768     = 32'd32768;
   localparam logic [17:0] PRESSURE_MAX = 18'h3FFFF;
endpackage
`default_nettype wire

// ----- design/bsc_stream_if.sv -----
// Valid/ready channel interfaces for the compensation block.
// Depends on nothing; payload widths follow the item fields.
`default_nettype none
interface bsc_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [23:0] raw_sample;
   modport source (output valid, output operation, output raw_sample, input ready);
   modport sink (input valid, input operation, input raw_sample, output ready);
endinterface

interface bsc_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic signed [15:0] temperature_tenths;
   logic        [17:0] pressure_pa;
   logic               divide_fault;
   modport source (output valid, output result_kind, output temperature_tenths,
                   output pressure_pa, output divide_fault, input ready);
   modport sink (input valid, input result_kind, input temperature_tenths,
                 input pressure_pa, input divide_fault, output ready);
endinterface
`default_nettype wire

// ----- design/bsc_divider.sv -----
// Radix-2 restoring divider for 32-bit unsigned operands, one bit per cycle.
// Depends on bsc_pkg.
`default_nettype none
module bsc_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   import bsc_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != 6'd0)
      else $error("divider busy with zero count");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(cnt_ff) == 6'd1)
      else $error("divider finished early");
endmodule
`default_nettype wire

// ----- design/barometric_sensor_compensation.sv -----
// Top level of the barometric sensor compensation block.
// Depends on bsc_pkg, bsc_stream_if and bsc_divider.
//
// Compensates raw temperature and pressure conversions with the standard
// integer algorithm, using calibration pairs written through the csr port.
// One item is taken at a time: req.ready is high only while the sequencer
// is idle. A finished item waits in the sequencer until the output register
// is free, so a stalled result also blocks the next input.
// A zero divisor skips the division. A result's timing is set by the shared
// 32x32 multiplier (low 32 bits of one product a cycle, registered) and the
// one-bit-a-cycle divider; any result stall adds to it. The temperature term
// is stored only after a good division; a zero divisor sets divide_fault.
`default_nettype none
module barometric_sensor_compensation (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bsc_req_if.sink                                  req,
   bsc_rsp_if.source                                rsp,
   input  wire logic                                csr_write_enable,
   input  wire logic [bsc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [bsc_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import bsc_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_DIVW  = 8'b0000_0100,
      S_DONE  = 8'b0000_1000,
      S_CLAMP = 8'b0001_0000
   } state_type;

   // calibration
   logic [31:0] pair_a_ff, pair_b_ff, pair_c_ff, pair_d_ff, pair_e_ff;
   logic [1:0]  oss_ff;
   logic [31:0] b5_ff, b5_in;

   state_type   state_ff, state_in;
   logic [4:0]  step_ff, step_in;
   logic        op_ff, op_in;
   logic [23:0] raw_ff, raw_in;

   // working registers
   logic [31:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic [31:0] r4_ff, r4_in, r5_ff, r5_in;
   logic [31:0] prod_ff;
   logic [31:0] mul_a, mul_b;
   logic [31:0] mul_full;

   logic        div_start;
   logic [31:0] div_n, div_d, div_q;
   logic        div_done;
   logic        neg_ff, neg_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff, rsp_kind_in;
   logic [15:0] rsp_temp_ff, rsp_temp_in;
   logic [17:0] rsp_pres_ff, rsp_pres_in;
   logic        rsp_fault_ff, rsp_fault_in;

   function automatic logic [31:0] sx16(input logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] absv(input logic [31:0] x);
      return x[31] ? 32'd0 - x : x;
   endfunction

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(pair_a_ff[31:16]);
   assign ac2 = sx16(pair_a_ff[15:0]);
   assign ac3 = sx16(pair_b_ff[31:16]);
   assign ac4 = {16'd0, pair_b_ff[15:0]};
   assign ac5 = {16'd0, pair_c_ff[31:16]};
   assign ac6 = {16'd0, pair_c_ff[15:0]};
   assign b1  = sx16(pair_d_ff[31:16]);
   assign b2  = sx16(pair_d_ff[15:0]);
   assign mc  = sx16(pair_e_ff[31:16]);
   assign md  = sx16(pair_e_ff[15:0]);

   // Only the low 32 bits of a product are ever used.
   assign mul_full = mul_a * mul_b;

   bsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req.ready = (state_ff == S_IDLE);

   // Sequencer: a step may feed the multiplier and may fold the previous
   // registered product into a working register.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_in        = op_ff;
      raw_in       = raw_ff;
      b5_in        = b5_ff;
      r0_in = r0_ff; r1_in = r1_ff; r2_in = r2_ff;
      r3_in = r3_ff; r4_in = r4_ff; r5_in = r5_ff;
      neg_in       = neg_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_n        = '0;
      div_d        = '0;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_pres_in  = rsp_pres_ff;
      rsp_fault_in = rsp_fault_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in    = req.operation;
               raw_in   = req.raw_sample;
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            step_in = step_ff + 5'd1;
            if (op_ff == OP_TEMPERATURE) begin
               case (step_ff)
                  5'd0: begin
                     mul_a = {16'd0, raw_ff[15:0]} - ac6; mul_b = ac5;
                  end
                  5'd1: begin
                     mul_a = mc; mul_b = 32'd2048;
                     r0_in = asr(prod_ff, 5'd15);        // x1
                  end
                  5'd2: begin
                     r1_in = prod_ff;                    // mc*2048
                     r2_in = r0_ff + md;                 // den
                     if (r0_ff + md == 32'd0) begin
                        state_in = S_DONE;
                        r5_in    = 32'd1;
                     end else begin
                        div_start = 1'b1;
                        div_n     = absv(prod_ff);
                        div_d     = absv(r0_ff + md);
                        neg_in    = prod_ff[31] ^ (r0_ff[31:0] + md >= SIGN_BIT);
                        r5_in     = 32'd0;
                        state_in  = S_DIVW;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end else begin
               case (step_ff)
                  5'd0: begin
                     r0_in = b5_ff - B6_OFFSET;          // b6
                     r1_in = {8'd0, raw_ff} >> (4'd8 - {2'd0, oss_ff}); // up
                  end
                  5'd1: begin mul_a = r0_ff; mul_b = r0_ff; end
                  5'd2: begin
                     r2_in = asr(prod_ff, 5'd12);        // sq
                     mul_a = ac2; mul_b = r0_ff;
                  end
                  5'd3: begin
                     r3_in = asr(prod_ff, 5'd11);        // ac2*b6 >> 11
                     mul_a = b2; mul_b = r2_ff;
                  end
                  5'd4: begin
                     r3_in = r3_ff + asr(prod_ff, 5'd11); // x3
                     mul_a = ac3; mul_b = r0_ff;
                  end
                  5'd5: begin
                     r4_in = asr(prod_ff, 5'd13);
                     mul_a = b1; mul_b = r2_ff;
                     // b3
                     r3_in = asr(((ac1 << 2) + r3_ff << oss_ff) + 32'd2, 5'd2);
                  end
                  5'd6: begin
                     r4_in = asr(r4_ff + asr(prod_ff, 5'd16) + 32'd2, 5'd2);
                  end
                  5'd7: begin
                     mul_a = ac4; mul_b = r4_ff + C_32768;
                  end
                  5'd8: begin
                     r4_in = prod_ff >> 15;              // b4
                     mul_a = r1_ff - r3_ff; mul_b = C_50000 >> oss_ff;
                  end
                  5'd9: begin
                     r2_in = prod_ff;                    // b7
                     if (r4_ff == 32'd0) begin
                        r5_in    = 32'd1;
                        state_in = S_DONE;
                     end else begin
                        r5_in     = 32'd0;
                        div_start = 1'b1;
                        div_n     = prod_ff[31] ? prod_ff : prod_ff << 1;
                        div_d     = r4_ff;
                        neg_in    = prod_ff[31];
                        state_in  = S_DIVW;
                     end
                  end
                  5'd10: begin
                     mul_a = asr(r0_ff, 5'd8); mul_b = asr(r0_ff, 5'd8);
                  end
                  5'd11: begin mul_a = prod_ff; mul_b = C_3038; end
                  5'd12: begin
                     r1_in = asr(prod_ff, 5'd16);
                     mul_a = C_M7357; mul_b = r0_ff;
                  end
                  5'd13: begin
                     r0_in = r0_ff + asr(r1_ff + asr(prod_ff, 5'd16) + C_3791, 5'd4);
                     state_in = S_CLAMP;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_DIVW: begin
            if (div_done) begin
               if (op_ff == OP_TEMPERATURE) begin
                  b5_in    = r0_ff + (neg_ff ? 32'd0 - div_q : div_q);
                  r0_in    = r0_ff + (neg_ff ? 32'd0 - div_q : div_q);
                  state_in = S_DONE;
               end else begin
                  r0_in    = neg_ff ? div_q << 1 : div_q;  // p
                  step_in  = 5'd10;
                  state_in = S_MUL;
               end
            end
         end
         S_CLAMP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            // Hold until the output register is free or drains this cycle.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = op_ff;
               rsp_fault_in = r5_ff[0];
               rsp_temp_in  = '0;
               rsp_pres_in  = '0;
               if (!r5_ff[0]) begin
                  if (op_ff == OP_TEMPERATURE) begin
                     rsp_temp_in = 16'(asr(r0_ff + 32'd8, 5'd4));
                  end else if (r0_ff[31]) begin
                     rsp_pres_in = '0;
                  end else if (r0_ff > {14'd0, PRESSURE_MAX}) begin
                     rsp_pres_in = PRESSURE_MAX;
                  end else begin
                     rsp_pres_in = r0_ff[17:0];
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         b5_ff        <= '0;
         pair_a_ff    <= '0;
         pair_b_ff    <= '0;
         pair_c_ff    <= '0;
         pair_d_ff    <= '0;
         pair_e_ff    <= '0;
         oss_ff       <= 2'd3;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         b5_ff        <= b5_in;
         step_ff      <= step_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_PAIR_A: pair_a_ff <= csr_write_data;
               REG_PAIR_B: pair_b_ff <= csr_write_data;
               REG_PAIR_C: pair_c_ff <= csr_write_data;
               REG_PAIR_D: pair_d_ff <= csr_write_data;
               REG_PAIR_E: pair_e_ff <= csr_write_data;
               REG_OSS:    oss_ff    <= csr_write_data[1:0];
               default: ;
            endcase
         end
      end
      op_ff        <= op_in;
      raw_ff       <= raw_in;
      r0_ff <= r0_in; r1_ff <= r1_in; r2_ff <= r2_in;
      r3_ff <= r3_in; r4_ff <= r4_in; r5_ff <= r5_in;
      neg_ff       <= neg_in;
      prod_ff      <= mul_full;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_temp_ff  <= rsp_temp_in;
      rsp_pres_ff  <= rsp_pres_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.result_kind        = rsp_kind_ff;
   assign rsp.temperature_tenths = rsp_temp_ff;
   assign rsp.pressure_pa        = rsp_pres_ff;
   assign rsp.divide_fault       = rsp_fault_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIVW)
      else $error("division result with no waiting step");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fault_ff |-> rsp_pres_ff == 18'd0 && rsp_temp_ff == 16'd0)
      else $error("fault with nonzero result");
endmodule
`default_nettype wire

// ----- sim/barometric_sensor_compensation_tb.sv -----
// Self-checking testbench for the barometric sensor compensation block.
// Depends on bsc_pkg, bsc_stream_if and the barometric_sensor_compensation RTL.
`default_nettype none
module barometric_sensor_compensation_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsc_pkg::*;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] tenths;
      logic        [17:0] pascals;
      logic               fault;
   } reading_type;

   // Compensation predictor: own copy of the calibration words and the
   // stored temperature term.
   class compensation_board;
      logic [31:0] pair_a, pair_b, pair_c, pair_d, pair_e;
      logic [1:0]  oss;
      logic [31:0] temp_base;
      reading_type pending[$];
      int          errors;

      function new();
         pair_a = '0; pair_b = '0; pair_c = '0; pair_d = '0; pair_e = '0;
         oss = 2'd3; temp_base = '0; errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_PAIR_A: pair_a = v;
            REG_PAIR_B: pair_b = v;
            REG_PAIR_C: pair_c = v;
            REG_PAIR_D: pair_d = v;
            REG_PAIR_E: pair_e = v;
            REG_OSS:    oss = v[1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] sx(logic [15:0] h);
         return {{16{h[15]}}, h};
      endfunction

      function logic [31:0] asr(logic [31:0] x, int n);
         return $unsigned($signed(x) >>> n);
      endfunction

      function logic [31:0] sdiv(logic [31:0] n, logic [31:0] d);
         logic [31:0] mn, md, q;
         mn = n[31] ? -n : n;
         md = d[31] ? -d : d;
         q = mn / md;
         return (n[31] != d[31]) ? -q : q;
      endfunction

      // Note an accepted input item and queue its expected result.
      function void note_sample(logic op, logic [23:0] raw);
         reading_type r;
         logic [31:0] ut, x1, x2, x3, den, b6, sq, b3, b4, b7, p, up;
         r = '0;
         r.kind = op;
         if (op == OP_TEMPERATURE) begin
            ut = {16'd0, raw[15:0]};
            x1 = asr((ut - {16'd0, pair_c[15:0]}) * {16'd0, pair_c[31:16]}, 15);
            den = x1 + sx(pair_e[15:0]);
            if (den == 0) begin
               r.fault = 1'b1;
            end else begin
               x2 = sdiv(sx(pair_e[31:16]) * 32'd2048, den);
               temp_base = x1 + x2;
               r.tenths = 16'(asr(temp_base + 32'd8, 4));
            end
         end else begin
            up = {8'd0, raw} >> (8 - oss);
            b6 = temp_base - B6_OFFSET;
            sq = asr(b6 * b6, 12);
            x1 = asr(sx(pair_d[15:0]) * sq, 11);
            x2 = asr(sx(pair_a[15:0]) * b6, 11);
            x3 = x1 + x2;
            b3 = asr(((sx(pair_a[31:16]) * 32'd4 + x3) << oss) + 32'd2, 2);
            x1 = asr(sx(pair_b[31:16]) * b6, 13);
            x2 = asr(sx(pair_d[31:16]) * sq, 16);
            x3 = asr(x1 + x2 + 32'd2, 2);
            b4 = ({16'd0, pair_b[15:0]} * (x3 + C_32768)) >> 15;
            b7 = (up - b3) * (C_50000 >> oss);
            if (b4 == 0) begin
               r.fault = 1'b1;
            end else begin
               p = (b7 < SIGN_BIT) ? (b7 << 1) / b4 : (b7 / b4) << 1;
               x1 = asr(p, 8) * asr(p, 8);
               x1 = asr(x1 * C_3038, 16);
               x2 = asr(C_M7357 * p, 16);
               p = p + asr(x1 + x2 + C_3791, 4);
               if (p[31]) r.pascals = '0;
               else if (p > {14'd0, PRESSURE_MAX}) r.pascals = PRESSURE_MAX;
               else r.pascals = p[17:0];
            end
         end
         pending.push_back(r);
      endfunction

      // Compare a result with the oldest expectation, field by field.
      function void check_reading(reading_type got);
         reading_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item kind=%0d", got.kind);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, got.kind); errors++;
         end
         if (got.tenths !== e.tenths) begin
            $error("temperature_tenths exp %0d got %0d", e.tenths, got.tenths); errors++;
         end
         if (got.pascals !== e.pascals) begin
            $error("pressure_pa exp %0d got %0d", e.pascals, got.pascals); errors++;
         end
         if (got.fault !== e.fault) begin
            $error("divide_fault exp %0d got %0d", e.fault, got.fault); errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;
   int          src_idle_pct, snk_stall_pct;
   longint      cycle_count;
   compensation_board board;

   bsc_req_if req ();
   bsc_rsp_if rsp ();

   barometric_sensor_compensation dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run; the slowest correct run is far below this.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 1_500_000) begin
            $display("FAIL barometric_sensor_compensation");
            $finish;
         end
      end
   end

   // Result side: stall at random, check each accepted item.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready)
            board.check_reading({rsp.result_kind, rsp.temperature_tenths,
                                 rsp.pressure_pa, rsp.divide_fault});
         rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   // Write one register; then wait with the write enable low before returning.
   task automatic write_csr(logic [2:0] idx, logic [31:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   // Offer one item; insert idle cycles first, hold until accepted.
   task automatic send_sample(logic op, logic [23:0] raw);
      while ($urandom_range(99) < src_idle_pct) @(posedge clock);
      req.valid <= 1'b1;
      req.operation <= op;
      req.raw_sample <= raw;
      do @(posedge clock); while (!req.ready);
      board.note_sample(op, raw);
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain: wait until every expected result has come, then settle.
   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Datasheet-like calibration with random jitter in each half.
   task automatic load_typical();
      write_csr(REG_PAIR_A, {16'd408 + 16'($urandom_range(400)),
                             16'hFEA0 + 16'($urandom_range(200))});
      write_csr(REG_PAIR_B, {16'hC6E0 + 16'($urandom_range(400)),
                             16'd32741 + 16'($urandom_range(2000))});
      write_csr(REG_PAIR_C, {16'd32757 + 16'($urandom_range(2000)),
                             16'd23153 + 16'($urandom_range(2000))});
      write_csr(REG_PAIR_D, {16'd6190 + 16'($urandom_range(100)),
                             16'd4 + 16'($urandom_range(8))});
      write_csr(REG_PAIR_E, {16'hD4BD + 16'($urandom_range(400)),
                             16'd2868 + 16'($urandom_range(400))});
      write_csr(REG_OSS, 32'($urandom_range(3)));
   endtask

   task automatic set_idling(int phase);
      case (phase % 4)
         0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         1: begin src_idle_pct = 82; snk_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  snk_stall_pct = 82; end
         default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
   endtask

   initial begin
      logic [23:0] raw;
      logic        op;
      board = new();
      src_idle_pct = 0;
      snk_stall_pct = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.operation = OP_TEMPERATURE;
      req.raw_sample = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset calibration: pressure before any temperature, zero divisors.
      send_sample(OP_PRESSURE, 24'hFFFFFF);
      send_sample(OP_TEMPERATURE, 24'h000000);
      drain();

      // Directed: typical calibration, field extremes, both operations.
      load_typical();
      write_csr(REG_OSS, 32'd0);
      send_sample(OP_TEMPERATURE, 24'd27898);
      send_sample(OP_PRESSURE, 24'd23843 << 8);
      send_sample(OP_TEMPERATURE, 24'h00FFFF);
      send_sample(OP_PRESSURE, 24'h000000);
      send_sample(OP_TEMPERATURE, 24'hFF0000);
      send_sample(OP_PRESSURE, 24'hFFFFFF);
      drain();
      write_csr(REG_OSS, 32'hFFFF_FFFF);
      send_sample(OP_TEMPERATURE, 24'hAA5555);
      send_sample(OP_PRESSURE, 24'hFFFFFF);
      send_sample(OP_PRESSURE, 24'h000000);
      drain();
      // Ignored register index; extreme words make wraps and clamps likely.
      write_csr(3'd7, 32'hFFFF_FFFF);
      write_csr(REG_PAIR_A, 32'h7FFF_8000);
      write_csr(REG_PAIR_B, 32'h8000_FFFF);
      write_csr(REG_PAIR_C, 32'hFFFF_FFFF);
      write_csr(REG_PAIR_D, 32'h7FFF_7FFF);
      write_csr(REG_PAIR_E, 32'h8000_7FFF);
      send_sample(OP_TEMPERATURE, 24'h000000);
      send_sample(OP_PRESSURE, 24'h800000);
      send_sample(OP_TEMPERATURE, 24'h00FFFF);
      send_sample(OP_PRESSURE, 24'h7FFFFF);
      drain();
      // Temperature divisor zero: ut == ac6 gives x1 0, md 0.
      write_csr(REG_PAIR_C, 32'h1234_5678);
      write_csr(REG_PAIR_E, 32'h1000_0000);
      send_sample(OP_TEMPERATURE, 24'h005678);
      drain();
      // Pressure divisor zero: ac4 0.
      write_csr(REG_PAIR_B, 32'h0100_0000);
      send_sample(OP_PRESSURE, 24'h123456);
      drain();

      // Random phases: mostly realistic calibration, some raw random words.
      for (int phase = 0; phase < 12; phase++) begin
         set_idling(phase);
         if (phase % 3 == 2) begin
            write_csr(REG_PAIR_A, $urandom());
            write_csr(REG_PAIR_B, $urandom());
            write_csr(REG_PAIR_C, $urandom());
            write_csr(REG_PAIR_D, $urandom());
            write_csr(REG_PAIR_E, $urandom());
            write_csr(REG_OSS, $urandom());
         end else begin
            load_typical();
         end
         for (int n = 0; n < 75; n++) begin
            op = 1'($urandom_range(1));
            case ($urandom_range(3))
               0: raw = 24'($urandom());
               1: raw = op ? 24'($urandom_range(20000, 40000)) << 8
                           : {8'($urandom()), 16'($urandom_range(20000, 35000))};
               default: raw = op ? 24'($urandom_range(4_000_000, 12_000_000))
                                 : {8'($urandom()), 16'($urandom())};
            endcase
            send_sample(op, raw);
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS barometric_sensor_compensation");
      end else begin
         $display("FAIL barometric_sensor_compensation");
      end
      $finish;
   end
endmodule
`default_nettype wire
